[hw/rtl/jzdm_pkg.sv]
// ----------------------------------------------------------------------------
// jzdm_pkg
// Shared types, constants and helper functions of the joystick drive mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jzdm_pkg;

  // field widths
  localparam int JOY_W      = 12;
  localparam int DUTY_W     = 8;
  localparam int DIR_W      = 4;
  localparam int OFFSET_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // square root datapath
  localparam int RAD_W       = 2 * JOY_W;
  localparam int ROOT_W      = JOY_W;
  localparam int REM_W       = ROOT_W + 1;
  localparam int SQRT_STEPS  = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

  // speed shaping
  localparam logic [JOY_W-1:0]  CENTRE     = 12'd2048;
  localparam logic [DUTY_W-1:0] SPEED_CAP  = 8'd255;
  localparam logic [DUTY_W-1:0] KNEE       = 8'd50;
  localparam logic [DUTY_W-1:0] KNEE_BASE  = 8'd150;
  // 105 / 205 as a fixed point reciprocal: 105 * ceil(2^24 / 205)
  localparam logic [23:0]       KNEE_RECIP = 24'd8593305;
  localparam int                KNEE_SHIFT = 24;
  localparam int                KNEE_Q_W   = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_OFFSET    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd2;

  localparam logic [OFFSET_W-1:0] TURN_OFFSET_RST    = 8'd100;
  localparam logic [JOY_W-1:0]    LOW_THRESHOLD_RST  = 12'd1800;
  localparam logic [JOY_W-1:0]    HIGH_THRESHOLD_RST = 12'd2200;

  // motion codes
  localparam logic [DIR_W-1:0] DIR_STOP      = 4'd0;
  localparam logic [DIR_W-1:0] DIR_FWD       = 4'd1;
  localparam logic [DIR_W-1:0] DIR_FWD_LEFT  = 4'd2;
  localparam logic [DIR_W-1:0] DIR_FWD_RIGHT = 4'd3;
  localparam logic [DIR_W-1:0] DIR_LEFT      = 4'd4;
  localparam logic [DIR_W-1:0] DIR_RIGHT     = 4'd5;
  localparam logic [DIR_W-1:0] DIR_BWD       = 4'd6;
  localparam logic [DIR_W-1:0] DIR_BWD_LEFT  = 4'd7;
  localparam logic [DIR_W-1:0] DIR_BWD_RIGHT = 4'd8;

  typedef enum logic [1:0] {
    BAND_LOW,
    BAND_MID,
    BAND_HIGH
  } band_t;

  typedef struct packed {
    logic [JOY_W-1:0] joy_x;
    logic [JOY_W-1:0] joy_y;
  } sample_t;

  typedef struct packed {
    logic [DIR_W-1:0]  direction;
    logic [DUTY_W-1:0] duty_ch0;
    logic [DUTY_W-1:0] duty_ch1;
    logic [DUTY_W-1:0] duty_ch2;
    logic [DUTY_W-1:0] duty_ch3;
  } drive_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] turn_offset;
    logic [JOY_W-1:0]    low_threshold;
    logic [JOY_W-1:0]    high_threshold;
  } cfg_t;

  typedef struct packed {
    band_t bx;
    band_t by;
  } zone_t;

  typedef struct packed {
    logic [RAD_W-1:0] radicand;
    zone_t            zone;
  } rad_word_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    zone_t             zone;
  } root_word_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_state_t;

  function automatic logic [JOY_W-1:0] abs_offset(input logic [JOY_W-1:0] v);
    return v[JOY_W-1] ? v - CENTRE : CENTRE - v;
  endfunction

  function automatic band_t band_of(input logic [JOY_W-1:0] v,
                                    input logic [JOY_W-1:0] lo,
                                    input logic [JOY_W-1:0] hi);
    band_t b;
    if (v < lo) begin
      b = BAND_LOW;
    end else if (v < hi) begin
      b = BAND_MID;
    end else begin
      b = BAND_HIGH;
    end
    return b;
  endfunction

  // one digit of the shift-and-subtract square root
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t st, input logic [1:0] pair);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    sqrt_state_t      nxt;
    cur   = {st.rem, pair};
    trial = (REM_W + 2)'({st.root, 2'b01});
    if (cur >= trial) begin
      nxt.rem  = REM_W'(cur - trial);
      nxt.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = REM_W'(cur);
      nxt.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

[hw/rtl/jzdm_front.sv]
// ----------------------------------------------------------------------------
// jzdm_front
// Two stages: centre offsets and zone bands, then the squared magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jzdm_front (
  input  logic                clk,
  input  logic                rst,
  input  jzdm_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  jzdm_pkg::sample_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output jzdm_pkg::rad_word_t out_word
);

  logic                         v1;
  logic                         v2;
  logic                         adv1;
  logic                         adv2;
  logic [jzdm_pkg::JOY_W-1:0]   dx;
  logic [jzdm_pkg::JOY_W-1:0]   dy;
  jzdm_pkg::zone_t              zone1;
  jzdm_pkg::zone_t              zone2;
  logic [jzdm_pkg::RAD_W-1:0]   radicand;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      dx       <= jzdm_pkg::abs_offset(in_word.joy_x);
      dy       <= jzdm_pkg::abs_offset(in_word.joy_y);
      zone1.bx <= jzdm_pkg::band_of(in_word.joy_x, cfg.low_threshold, cfg.high_threshold);
      zone1.by <= jzdm_pkg::band_of(in_word.joy_y, cfg.low_threshold, cfg.high_threshold);
    end
    if (adv2) begin
      radicand <= jzdm_pkg::RAD_W'(dx) * jzdm_pkg::RAD_W'(dx)
                + jzdm_pkg::RAD_W'(dy) * jzdm_pkg::RAD_W'(dy);
      zone2    <= zone1;
    end
  end

  assign out_valid         = v2;
  assign out_word.radicand = radicand;
  assign out_word.zone     = zone2;

endmodule

[hw/rtl/jzdm_sqrt.sv]
// ----------------------------------------------------------------------------
// jzdm_sqrt
// Pipelined integer square root, a fixed number of root bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jzdm_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jzdm_pkg::rad_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jzdm_pkg::root_word_t out_word
);

  localparam int NS = jzdm_pkg::SQRT_STAGES;

  wire  [NS-1:0]               valid_q;
  wire  [NS-1:0]               adv;
  wire  [NS-1:0]               down_ready;
  wire  [NS-1:0]               src_valid;
  jzdm_pkg::sqrt_state_t       st_q   [NS];
  jzdm_pkg::sqrt_state_t       st_src [NS];
  jzdm_pkg::sqrt_state_t       st_nxt [NS];
  logic [jzdm_pkg::RAD_W-1:0]  rad_q  [NS];
  logic [jzdm_pkg::RAD_W-1:0]  rad_src[NS];
  jzdm_pkg::zone_t             zone_q [NS];
  jzdm_pkg::zone_t             zone_src[NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic v;

    if (j == 0) begin : g_first
      assign src_valid[j] = in_valid;
      assign st_src[j]    = '0;
      assign rad_src[j]   = in_word.radicand;
      assign zone_src[j]  = in_word.zone;
    end else begin : g_next
      assign src_valid[j] = valid_q[j-1];
      assign st_src[j]    = st_q[j-1];
      assign rad_src[j]   = rad_q[j-1];
      assign zone_src[j]  = zone_q[j-1];
    end

    if (j == NS - 1) begin : g_last
      assign down_ready[j] = out_ready;
    end else begin : g_mid
      assign down_ready[j] = adv[j+1];
    end

    assign valid_q[j] = v;
    assign adv[j]     = !v || down_ready[j];

    always_comb begin
      jzdm_pkg::sqrt_state_t st;
      st = st_src[j];
      for (int k = 0; k < jzdm_pkg::SQRT_STEPS; k++) begin
        st = jzdm_pkg::sqrt_step(st,
          rad_src[j][jzdm_pkg::RAD_W - 1 - 2 * (j * jzdm_pkg::SQRT_STEPS + k) -: 2]);
      end
      st_nxt[j] = st;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (adv[j]) begin
        v <= src_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[j]) begin
        st_q[j]   <= st_nxt[j];
        rad_q[j]  <= rad_src[j];
        zone_q[j] <= zone_src[j];
      end
    end
  end

  assign in_ready      = adv[0];
  assign out_valid     = valid_q[NS-1];
  assign out_word.root = st_q[NS-1].root;
  assign out_word.zone = zone_q[NS-1];

endmodule

[hw/rtl/jzdm_mix.sv]
// ----------------------------------------------------------------------------
// jzdm_mix
// Speed cap and knee remap, then wheel mixing into bridge duties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jzdm_mix (
  input  logic                 clk,
  input  logic                 rst,
  input  jzdm_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jzdm_pkg::root_word_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jzdm_pkg::drive_t     out_word
);

  logic                            v1;
  logic                            v2;
  logic                            adv1;
  logic                            adv2;
  logic [jzdm_pkg::DUTY_W-1:0]     capped;
  logic [jzdm_pkg::DUTY_W-1:0]     knee_diff;
  logic [31:0]                     knee_prod;
  logic [jzdm_pkg::DUTY_W-1:0]     base_q;
  logic                            knee_q;
  logic [jzdm_pkg::KNEE_Q_W-1:0]   quot_q;
  jzdm_pkg::zone_t                 zone1;
  logic [jzdm_pkg::DUTY_W-1:0]     speed;
  logic [jzdm_pkg::DUTY_W-1:0]     slow;
  logic [jzdm_pkg::DUTY_W-1:0]     left;
  logic [jzdm_pkg::DUTY_W-1:0]     right;
  jzdm_pkg::drive_t                drive_next;
  jzdm_pkg::drive_t                drive;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // root / 8, limited to the cap
  always_comb begin
    capped    = in_word.root[jzdm_pkg::ROOT_W-1] ? jzdm_pkg::SPEED_CAP
                                                 : in_word.root[jzdm_pkg::ROOT_W-2:3];
    knee_diff = capped - jzdm_pkg::KNEE;
    knee_prod = 32'(knee_diff) * 32'(jzdm_pkg::KNEE_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      base_q <= capped;
      knee_q <= capped > jzdm_pkg::KNEE;
      quot_q <= knee_prod[jzdm_pkg::KNEE_SHIFT +: jzdm_pkg::KNEE_Q_W];
      zone1  <= in_word.zone;
    end
    if (adv2) begin
      drive <= drive_next;
    end
  end

  always_comb begin
    speed = knee_q ? jzdm_pkg::KNEE_BASE + jzdm_pkg::DUTY_W'(quot_q) : base_q;
    slow  = (speed > cfg.turn_offset) ? speed - cfg.turn_offset : '0;
    left  = speed;
    right = speed;
    case (zone1.bx)
      jzdm_pkg::BAND_LOW:  right = slow;
      jzdm_pkg::BAND_HIGH: left  = slow;
      default: ;
    endcase

    drive_next = '0;
    case (zone1.by)
      jzdm_pkg::BAND_LOW: begin
        case (zone1.bx)
          jzdm_pkg::BAND_LOW:  drive_next.direction = jzdm_pkg::DIR_BWD_LEFT;
          jzdm_pkg::BAND_HIGH: drive_next.direction = jzdm_pkg::DIR_BWD_RIGHT;
          default:             drive_next.direction = jzdm_pkg::DIR_BWD;
        endcase
        drive_next.duty_ch0 = left;
        drive_next.duty_ch2 = right;
      end
      jzdm_pkg::BAND_MID: begin
        case (zone1.bx)
          jzdm_pkg::BAND_LOW: begin
            drive_next.direction = jzdm_pkg::DIR_LEFT;
            drive_next.duty_ch1  = speed;
            drive_next.duty_ch2  = speed;
          end
          jzdm_pkg::BAND_HIGH: begin
            drive_next.direction = jzdm_pkg::DIR_RIGHT;
            drive_next.duty_ch0  = speed;
            drive_next.duty_ch3  = speed;
          end
          default: drive_next.direction = jzdm_pkg::DIR_STOP;
        endcase
      end
      default: begin
        case (zone1.bx)
          jzdm_pkg::BAND_LOW:  drive_next.direction = jzdm_pkg::DIR_FWD_LEFT;
          jzdm_pkg::BAND_HIGH: drive_next.direction = jzdm_pkg::DIR_FWD_RIGHT;
          default:             drive_next.direction = jzdm_pkg::DIR_FWD;
        endcase
        drive_next.duty_ch1 = left;
        drive_next.duty_ch3 = right;
      end
    endcase
  end

  assign out_valid = v2;
  assign out_word  = drive;

endmodule

[hw/rtl/joystick_zone_drive_mixer_top.sv]
// ----------------------------------------------------------------------------
// joystick_zone_drive_mixer_top
// Joystick sample to dual H-bridge duties and motion code.
// Pipeline: 2 front stages, 6 square root stages and 2 mix stages between
//   sample accept and drive word valid.
// Throughput: one word per cycle while drive_stall is low; every stage holds under stall, bubbles close.
// Reset: pipeline empties, registers return to offset 100, thresholds 1800/2200.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module joystick_zone_drive_mixer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  jzdm_pkg::sample_t                   sample,
  output logic                                drive_valid,
  input  logic                                drive_stall,
  output jzdm_pkg::drive_t                    drive,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jzdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jzdm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  jzdm_pkg::cfg_t       cfg;
  logic                 front_ready;
  logic                 rad_valid;
  logic                 rad_ready;
  jzdm_pkg::rad_word_t  rad_word;
  logic                 root_valid;
  logic                 root_ready;
  jzdm_pkg::root_word_t root_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_offset    <= jzdm_pkg::TURN_OFFSET_RST;
      cfg.low_threshold  <= jzdm_pkg::LOW_THRESHOLD_RST;
      cfg.high_threshold <= jzdm_pkg::HIGH_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jzdm_pkg::CFG_TURN_OFFSET:    cfg.turn_offset    <= cfg_data[jzdm_pkg::OFFSET_W-1:0];
        jzdm_pkg::CFG_LOW_THRESHOLD:  cfg.low_threshold  <= cfg_data[jzdm_pkg::JOY_W-1:0];
        jzdm_pkg::CFG_HIGH_THRESHOLD: cfg.high_threshold <= cfg_data[jzdm_pkg::JOY_W-1:0];
        default: ;
      endcase
    end
  end

  assign sample_stall = !front_ready;

  jzdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample_valid),
    .in_ready  (front_ready),
    .in_word   (sample),
    .out_valid (rad_valid),
    .out_ready (rad_ready),
    .out_word  (rad_word)
  );

  jzdm_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rad_valid),
    .in_ready  (rad_ready),
    .in_word   (rad_word),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_word  (root_word)
  );

  jzdm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (root_valid),
    .in_ready  (root_ready),
    .in_word   (root_word),
    .out_valid (drive_valid),
    .out_ready (!drive_stall),
    .out_word  (drive)
  );

endmodule
